>>> src/sukt_pkg.sv
package sukt_pkg;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEF = 64;
   localparam int KEY_BITS_DEF = 16;

   // Field widths of the request and response items
   localparam int ACTION_W    = 3;
   localparam int KEY_FIELD_W = 16;
   localparam int AGE_W       = 7;
   localparam int STATUS_W    = 3;
   localparam int ENT_W       = 7;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_PAD_W   = RSP_DATA_W - KEY_FIELD_W - AGE_W - ENT_W;

   // Request action codes
   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_LIST   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DRAIN  = 3'd4;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_DUP      = 3'd1,
      STAT_NOTFOUND = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_EMPTY    = 3'd4
   } sukt_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UP_PRIME,
      ST_UP_MOVE,
      ST_DN_MOVE,
      ST_LIST,
      ST_RESP
   } sukt_state_type;

   // Table read address source
   typedef enum logic [2:0] {
      RD_ZERO,
      RD_IDX,
      RD_INC1,
      RD_INC2,
      RD_DEC1,
      RD_DEC2
   } sukt_rd_sel_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_FILL,
      IDX_INC,
      IDX_DEC
   } sukt_idx_op_type;

   typedef enum logic {
      WR_SHIFT,
      WR_NEW
   } sukt_wr_sel_type;

   typedef enum logic [1:0] {
      FILL_HOLD,
      FILL_INC,
      FILL_DEC,
      FILL_CLEAR
   } sukt_fill_op_type;

   typedef enum logic [1:0] {
      AGE_ZERO,
      AGE_INPUT,
      AGE_STORED
   } sukt_age_sel_type;

   typedef enum logic {
      OUT_RESULT,
      OUT_RECORD
   } sukt_out_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic             take;
      logic             key_clear;
      sukt_rd_sel_type  rd_sel;
      sukt_idx_op_type  idx_op;
      logic             pos_ld;
      logic             mem_we;
      sukt_wr_sel_type  wr_sel;
      sukt_fill_op_type fill_op;
      logic             res_ld;
      sukt_status_type  res_status;
      sukt_age_sel_type res_age_sel;
      logic             out_ld;
      sukt_out_sel_type out_sel;
      logic             rec_zero_ent;
   } sukt_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_stop;
      logic scan_hit;
      logic full;
      logic empty;
      logic up_done;
      logic dn_more;
      logic rec_last;
      logic out_free;
   } sukt_stat_type;

endpackage

>>> src/sukt_dpath.sv
module sukt_dpath #(
   parameter int CAPACITY = sukt_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = sukt_pkg::KEY_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sukt_pkg::sukt_cmd_type           cmd,
   output sukt_pkg::sukt_stat_type          stat,
   input  logic [sukt_pkg::KEY_FIELD_W-1:0] req_key,
   input  logic [sukt_pkg::AGE_W-1:0]       req_age,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sukt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   output logic [sukt_pkg::STATUS_W-1:0]    rsp_tuser
);
   import sukt_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   // Record table
   logic [KEY_BITS-1:0] key_mem [CAPACITY];
   logic [AGE_W-1:0]    age_mem [CAPACITY];

   logic [KEY_BITS-1:0] rd_key_ff;
   logic [AGE_W-1:0]    rd_age_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic [KEY_BITS-1:0] wr_key;
   logic [AGE_W-1:0]    wr_age;
   logic [CNT_W:0]      rd_sum;

   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [CNT_W:0]      idx_next;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [AGE_W-1:0]    age_ff, age_in;
   logic [KEY_BITS+KEY_FIELD_W-1:0] key_ext;

   sukt_status_type     res_status_ff, res_status_in;
   logic [AGE_W-1:0]    res_age_ff, res_age_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0]         rsp_user_ff, rsp_user_in;
   logic [KEY_BITS+KEY_FIELD_W-1:0] out_key_ext;
   logic [CNT_W+ENT_W-1:0]      fill_ext;
   logic [KEY_FIELD_W-1:0]      out_key;
   logic [AGE_W-1:0]            out_age;
   logic [ENT_W-1:0]            out_ent;

   // Key from the request, cut or widened to KEY_BITS
   assign key_ext = {{KEY_BITS{1'b0}}, req_key};

   // Status toward the controller
   assign idx_next       = {1'b0, idx_ff} + (CNT_W+1)'(1);
   assign stat.scan_stop = (idx_ff >= fill_ff) || (rd_key_ff >= key_ff);
   assign stat.scan_hit  = (idx_ff < fill_ff) && (rd_key_ff == key_ff);
   assign stat.full      = (fill_ff == CNT_W'(CAPACITY));
   assign stat.empty     = (fill_ff == '0);
   assign stat.up_done   = (idx_ff == pos_ff);
   assign stat.dn_more   = (idx_next < {1'b0, fill_ff});
   assign stat.rec_last  = (idx_next == {1'b0, fill_ff});
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   // Read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:  rd_sum = {1'b0, idx_ff};
         RD_INC1: rd_sum = {1'b0, idx_ff} + (CNT_W+1)'(1);
         RD_INC2: rd_sum = {1'b0, idx_ff} + (CNT_W+1)'(2);
         RD_DEC1: rd_sum = {1'b0, idx_ff} - (CNT_W+1)'(1);
         RD_DEC2: rd_sum = {1'b0, idx_ff} - (CNT_W+1)'(2);
         default: rd_sum = '0;
      endcase
   end
   assign rd_addr = rd_sum[ADDR_W-1:0];
   assign wr_addr = idx_ff[ADDR_W-1:0];

   // Write data: moved neighbor or new record
   always_comb begin
      case (cmd.wr_sel)
         WR_NEW: begin
            wr_key = key_ff;
            wr_age = age_ff;
         end
         default: begin
            wr_key = rd_key_ff;
            wr_age = rd_age_ff;
         end
      endcase
   end

   // Table memories, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         age_mem[wr_addr] <= wr_age;
      end
      rd_age_ff <= age_mem[rd_addr];
   end

   // Walk index, insert position and fill count
   always_comb begin
      case (cmd.idx_op)
         IDX_ZERO: idx_in = '0;
         IDX_FILL: idx_in = fill_ff;
         IDX_INC:  idx_in = idx_ff + CNT_W'(1);
         IDX_DEC:  idx_in = idx_ff - CNT_W'(1);
         default:  idx_in = idx_ff;
      endcase
      pos_in = cmd.pos_ld ? idx_ff : pos_ff;
      case (cmd.fill_op)
         FILL_INC:   fill_in = fill_ff + CNT_W'(1);
         FILL_DEC:   fill_in = fill_ff - CNT_W'(1);
         FILL_CLEAR: fill_in = '0;
         default:    fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         pos_ff  <= '0;
         fill_ff <= '0;
      end else begin
         idx_ff  <= idx_in;
         pos_ff  <= pos_in;
         fill_ff <= fill_in;
      end
   end

   // Request capture and single-result fields
   always_comb begin
      key_in = key_ff;
      age_in = age_ff;
      if (cmd.take) begin
         key_in = cmd.key_clear ? '0 : key_ext[KEY_BITS-1:0];
         age_in = req_age;
      end
      res_status_in = res_status_ff;
      res_age_in    = res_age_ff;
      if (cmd.res_ld) begin
         res_status_in = cmd.res_status;
         case (cmd.res_age_sel)
            AGE_INPUT:  res_age_in = age_ff;
            AGE_STORED: res_age_in = rd_age_ff;
            default:    res_age_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      age_ff        <= age_in;
      res_status_ff <= res_status_in;
      res_age_ff    <= res_age_in;
   end

   // Response register
   assign fill_ext = {{ENT_W{1'b0}}, fill_ff};

   always_comb begin
      case (cmd.out_sel)
         OUT_RECORD: begin
            out_key_ext = {{KEY_FIELD_W{1'b0}}, rd_key_ff};
            out_age     = rd_age_ff;
            out_ent     = cmd.rec_zero_ent ? '0 : fill_ext[ENT_W-1:0];
            rsp_last_in = stat.rec_last;
            rsp_user_in = STAT_OK;
         end
         default: begin
            out_key_ext = {{KEY_FIELD_W{1'b0}}, key_ff};
            out_age     = res_age_ff;
            out_ent     = fill_ext[ENT_W-1:0];
            rsp_last_in = 1'b1;
            rsp_user_in = res_status_ff;
         end
      endcase
      out_key     = out_key_ext[KEY_FIELD_W-1:0];
      rsp_data_in = {{RSP_PAD_W{1'b0}}, out_ent, out_age, out_key};
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A pending response is never overwritten
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> stat.out_free)
      else $error("response loaded over a pending one");

   // Table writes stay inside the table
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_we |-> (idx_ff < CNT_W'(CAPACITY)))
      else $error("table write out of range");

   // No insert into a full table
   a_fill_inc: assert property (@(posedge clock) disable iff (reset)
      (cmd.fill_op == FILL_INC) |-> !stat.full)
      else $error("fill count overflow");

   // No removal from an empty table
   a_fill_dec: assert property (@(posedge clock) disable iff (reset)
      (cmd.fill_op == FILL_DEC) |-> !stat.empty)
      else $error("fill count underflow");

endmodule

>>> src/sukt_ctrl.sv
module sukt_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sukt_pkg::ACTION_W-1:0] req_action,
   input  sukt_pkg::sukt_stat_type       stat,
   output sukt_pkg::sukt_cmd_type        cmd
);
   import sukt_pkg::*;

   sukt_state_type        state_ff, state_in;
   logic [ACTION_W-1:0]   op_ff, op_in;
   logic                  accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign op_in      = accept ? req_action : op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= ACT_INSERT;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action) inside
                  ACT_INSERT: state_in = ST_SCAN;
                  ACT_DELETE, ACT_SEARCH: state_in = stat.empty ? ST_RESP : ST_SCAN;
                  ACT_LIST, ACT_DRAIN: state_in = stat.empty ? ST_RESP : ST_LIST;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.scan_stop) begin
               if (op_ff == ACT_INSERT) begin
                  if (stat.scan_hit || stat.full) begin
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_UP_PRIME;
                  end
               end else if (op_ff == ACT_DELETE && stat.scan_hit) begin
                  state_in = ST_DN_MOVE;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_UP_PRIME: state_in = ST_UP_MOVE;
         ST_UP_MOVE: begin
            if (stat.up_done) begin
               state_in = ST_RESP;
            end
         end
         ST_DN_MOVE: begin
            if (!stat.dn_more) begin
               state_in = ST_RESP;
            end
         end
         ST_LIST: begin
            if (stat.out_free && stat.rec_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.rd_sel = RD_ZERO;
            cmd.idx_op = IDX_ZERO;
            if (accept) begin
               cmd.take = 1'b1;
               case (req_action) inside
                  ACT_DELETE, ACT_SEARCH: begin
                     cmd.res_ld      = stat.empty;
                     cmd.res_status  = STAT_EMPTY;
                     cmd.res_age_sel = AGE_ZERO;
                  end
                  ACT_LIST, ACT_DRAIN: begin
                     cmd.key_clear   = 1'b1;
                     cmd.res_ld      = stat.empty;
                     cmd.res_status  = STAT_EMPTY;
                     cmd.res_age_sel = AGE_ZERO;
                  end
                  default: cmd.res_ld = 1'b0;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.rd_sel = RD_INC1;
            if (!stat.scan_stop) begin
               cmd.idx_op = IDX_INC;
            end else begin
               cmd.pos_ld = 1'b1;
               cmd.res_ld = 1'b1;
               if (op_ff == ACT_INSERT) begin
                  if (stat.scan_hit) begin
                     cmd.res_status  = STAT_DUP;
                     cmd.res_age_sel = AGE_STORED;
                  end else begin
                     cmd.res_status  = STAT_FULL;
                     cmd.res_age_sel = AGE_INPUT;
                     cmd.idx_op      = IDX_FILL;
                  end
               end else if (stat.scan_hit) begin
                  cmd.res_status  = STAT_OK;
                  cmd.res_age_sel = AGE_STORED;
               end else begin
                  cmd.res_status  = STAT_NOTFOUND;
                  cmd.res_age_sel = AGE_ZERO;
               end
            end
         end
         ST_UP_PRIME: begin
            cmd.rd_sel = RD_DEC1;
         end
         ST_UP_MOVE: begin
            cmd.mem_we = 1'b1;
            if (!stat.up_done) begin
               cmd.wr_sel = WR_SHIFT;
               cmd.rd_sel = RD_DEC2;
               cmd.idx_op = IDX_DEC;
            end else begin
               cmd.wr_sel      = WR_NEW;
               cmd.fill_op     = FILL_INC;
               cmd.res_ld      = 1'b1;
               cmd.res_status  = STAT_OK;
               cmd.res_age_sel = AGE_INPUT;
            end
         end
         ST_DN_MOVE: begin
            if (stat.dn_more) begin
               cmd.mem_we = 1'b1;
               cmd.wr_sel = WR_SHIFT;
               cmd.rd_sel = RD_INC2;
               cmd.idx_op = IDX_INC;
            end else begin
               cmd.fill_op = FILL_DEC;
            end
         end
         ST_LIST: begin
            cmd.rd_sel       = RD_IDX;
            cmd.out_sel      = OUT_RECORD;
            cmd.rec_zero_ent = (op_ff == ACT_DRAIN);
            if (stat.out_free) begin
               cmd.out_ld = 1'b1;
               cmd.rd_sel = RD_INC1;
               cmd.idx_op = IDX_INC;
               if (stat.rec_last && op_ff == ACT_DRAIN) begin
                  cmd.fill_op = FILL_CLEAR;
               end
            end
         end
         ST_RESP: begin
            cmd.out_sel = OUT_RESULT;
            cmd.out_ld  = stat.out_free;
         end
         default: cmd.out_ld = 1'b0;
      endcase
   end

endmodule

>>> src/sorted_unique_key_table.sv
// Channel | Dir | Ports                        | Contents
// req     | in  | req_tvalid/tready/tdata/tuser | one request: action, key, age
// rsp     | out | rsp_tvalid/tready/tdata/tlast/tuser | one or more responses
//
// Insert and delete scan upward to the first entry not below the key, then,
// if they change the table, shift one entry per cycle. Search scans alike.
// List and drain give one record per cycle while rsp_tready is high.
// Reset is synchronous and empties the table by clearing the fill count only.
// A low rsp_tready holds the response register and pauses a listing; the
// next request is taken while the last response still waits.
module sorted_unique_key_table #(
   parameter int CAPACITY = sukt_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = sukt_pkg::KEY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] key, [22:16] age, [23] zero
   input  logic [sukt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [2:0] action
   input  logic [sukt_pkg::ACTION_W-1:0]   req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] found_key, [22:16] found_age, [29:23] entries, [31:30] zero
   output logic [sukt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // [2:0] status
   output logic [sukt_pkg::STATUS_W-1:0]   rsp_tuser
);
   import sukt_pkg::*;

   sukt_cmd_type  cmd;
   sukt_stat_type stat;

   sukt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   sukt_dpath #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_key    (req_tdata[KEY_FIELD_W-1:0]),
      .req_age    (req_tdata[KEY_FIELD_W+AGE_W-1:KEY_FIELD_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sukt_pkg::*;

   localparam int CAP = CAPACITY_DEF;
   localparam int KEY_BITS = KEY_BITS_DEF;
   localparam logic [31:0] KEY_MASK = (32'd1 << KEY_BITS) - 32'd1;
   localparam int SETTLE_CYCLES = CAP + 16;

   // action codes the block does not use
   localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_SPARE_MID   = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

   // one response of the table
   typedef struct packed {
      sukt_status_type status;
      logic [15:0]     key;
      logic [6:0]      age;
      logic            last;
      logic [6:0]      entries;
   } table_reply_type;

   // directed request, with its reply typed in where it is obvious
   typedef struct {
      logic [ACTION_W-1:0] act;
      logic [15:0]         key;
      logic [6:0]          age;
      bit                  typed;
      table_reply_type     reply;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [ACTION_W-1:0]   req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic [STATUS_W-1:0]   rsp_tuser;

   // mirror of the record table
   logic [15:0] shadow_keys [CAP];
   logic [6:0]  shadow_ages [CAP];
   int          shadow_fill;

   table_reply_type replies_due[$];
   int              mismatch_count = 0;
   bit              calm = 1'b0;

   directed_row_type directed_rows [24] = '{
      '{ACT_LIST,   16'h0000, 7'h00, 1'b1, '{STAT_EMPTY,    16'h0000, 7'h00, 1'b1, 7'd0}},
      '{ACT_DRAIN,  16'h1234, 7'h05, 1'b1, '{STAT_EMPTY,    16'h0000, 7'h00, 1'b1, 7'd0}},
      '{ACT_DELETE, 16'hFFFF, 7'h00, 1'b1, '{STAT_EMPTY,    16'hFFFF, 7'h00, 1'b1, 7'd0}},
      '{ACT_SEARCH, 16'h0000, 7'h7F, 1'b1, '{STAT_EMPTY,    16'h0000, 7'h00, 1'b1, 7'd0}},
      '{ACT_INSERT, 16'h0000, 7'h00, 1'b1, '{STAT_OK,       16'h0000, 7'h00, 1'b1, 7'd1}},
      '{ACT_INSERT, 16'hFFFF, 7'h7F, 1'b1, '{STAT_OK,       16'hFFFF, 7'h7F, 1'b1, 7'd2}},
      '{ACT_INSERT, 16'hFFFF, 7'h03, 1'b1, '{STAT_DUP,      16'hFFFF, 7'h7F, 1'b1, 7'd2}},
      '{ACT_INSERT, 16'h8000, 7'h55, 1'b1, '{STAT_OK,       16'h8000, 7'h55, 1'b1, 7'd3}},
      '{ACT_INSERT, 16'h7FFF, 7'h2A, 1'b0, '0},
      '{ACT_SEARCH, 16'hFFFF, 7'h00, 1'b1, '{STAT_OK,       16'hFFFF, 7'h7F, 1'b1, 7'd4}},
      '{ACT_SEARCH, 16'h0000, 7'h11, 1'b1, '{STAT_OK,       16'h0000, 7'h00, 1'b1, 7'd4}},
      '{ACT_SEARCH, 16'h1234, 7'h00, 1'b1, '{STAT_NOTFOUND, 16'h1234, 7'h00, 1'b1, 7'd4}},
      '{ACT_DELETE, 16'hAAAA, 7'h7F, 1'b1, '{STAT_NOTFOUND, 16'hAAAA, 7'h00, 1'b1, 7'd4}},
      '{ACT_SPARE_FIRST, 16'hFFFF, 7'h7F, 1'b0, '0},
      '{ACT_SPARE_MID, 16'h5555, 7'h2A, 1'b0, '0},
      '{ACT_SPARE_LAST, 16'h0000, 7'h00, 1'b0, '0},
      '{ACT_LIST,   16'hFFFF, 7'h7F, 1'b0, '0},
      '{ACT_DELETE, 16'h7FFF, 7'h00, 1'b0, '0},
      '{ACT_DELETE, 16'h0000, 7'h00, 1'b1, '{STAT_OK,       16'h0000, 7'h00, 1'b1, 7'd2}},
      '{ACT_INSERT, 16'h0001, 7'h7F, 1'b0, '0},
      '{ACT_DRAIN,  16'h0000, 7'h00, 1'b0, '0},
      '{ACT_LIST,   16'h0000, 7'h00, 1'b1, '{STAT_EMPTY,    16'h0000, 7'h00, 1'b1, 7'd0}},
      '{ACT_DELETE, 16'h8000, 7'h00, 1'b1, '{STAT_EMPTY,    16'h8000, 7'h00, 1'b1, 7'd0}},
      '{ACT_INSERT, 16'h5A5A, 7'h15, 1'b1, '{STAT_OK,       16'h5A5A, 7'h15, 1'b1, 7'd1}}
   };

   sorted_unique_key_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),  // [15:0] key, [22:16] age, [23] zero
      .req_tuser  (req_tuser),  // [2:0] action
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),  // [15:0] found_key, [22:16] found_age, [29:23] entries
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)   // [2:0] status
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch %0t: %s got %0h want %0h", $time, what, got, want);
   endtask

   function automatic void post_reply(input sukt_status_type st, input logic [15:0] k,
                                      input logic [6:0] a, input logic l, input int ent);
      table_reply_type r;
      r.status  = st;
      r.key     = k;
      r.age     = a;
      r.last    = l;
      r.entries = 7'(ent);
      replies_due.push_back(r);
   endfunction

   // apply one request to the mirror table and queue the replies it owes
   function automatic void apply_table_action(input logic [ACTION_W-1:0] act,
                                              input logic [15:0] key_in,
                                              input logic [6:0] age_in);
      logic [15:0] k;
      logic [6:0]  hit_age;
      int          pos;
      k = key_in & KEY_MASK[15:0];
      // first slot whose key is not below k
      pos = 0;
      while (pos < shadow_fill && shadow_keys[pos] < k) pos++;
      case (act)
         ACT_INSERT: begin
            if (pos < shadow_fill && shadow_keys[pos] == k) begin
               post_reply(STAT_DUP, k, shadow_ages[pos], 1'b1, shadow_fill);
            end else if (shadow_fill >= CAP) begin
               post_reply(STAT_FULL, k, age_in, 1'b1, shadow_fill);
            end else begin
               for (int i = shadow_fill; i > pos; i--) begin
                  shadow_keys[i] = shadow_keys[i-1];
                  shadow_ages[i] = shadow_ages[i-1];
               end
               shadow_keys[pos] = k;
               shadow_ages[pos] = age_in;
               shadow_fill++;
               post_reply(STAT_OK, k, age_in, 1'b1, shadow_fill);
            end
         end
         ACT_DELETE, ACT_SEARCH: begin
            if (shadow_fill == 0) begin
               post_reply(STAT_EMPTY, k, '0, 1'b1, 0);
            end else if (!(pos < shadow_fill && shadow_keys[pos] == k)) begin
               post_reply(STAT_NOTFOUND, k, '0, 1'b1, shadow_fill);
            end else begin
               hit_age = shadow_ages[pos];
               if (act == ACT_DELETE) begin
                  for (int i = pos; i + 1 < shadow_fill; i++) begin
                     shadow_keys[i] = shadow_keys[i+1];
                     shadow_ages[i] = shadow_ages[i+1];
                  end
                  shadow_fill--;
               end
               post_reply(STAT_OK, k, hit_age, 1'b1, shadow_fill);
            end
         end
         ACT_LIST, ACT_DRAIN: begin
            if (shadow_fill == 0) begin
               post_reply(STAT_EMPTY, '0, '0, 1'b1, 0);
            end else begin
               for (int i = 0; i < shadow_fill; i++)
                  post_reply(STAT_OK, shadow_keys[i], shadow_ages[i], i == shadow_fill - 1,
                             (act == ACT_DRAIN) ? 0 : shadow_fill);
               if (act == ACT_DRAIN) shadow_fill = 0;
            end
         end
         default: ;  // spare codes leave the table alone
      endcase
   endfunction

   // mostly keys that are stored or close together, so hits and misses mix
   function automatic logic [15:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (shadow_fill != 0 && roll < 50) return shadow_keys[$urandom_range(0, shadow_fill - 1)];
      if (roll < 75) return 16'($urandom_range(0, 40));
      if (roll < 82) return 16'hFFFF - 16'($urandom_range(0, 3));
      return 16'($urandom());
   endfunction

   // present one request, wait for the handshake, then maybe idle a while
   task automatic send_req(input logic [ACTION_W-1:0] act, input logic [15:0] key,
                           input logic [6:0] age, input bit typed = 1'b0,
                           input table_reply_type fixed = '0);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {1'b0, age, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_table_action(act, key, age);
      if (typed) begin
         void'(replies_due.pop_back());
         replies_due.push_back(fixed);
      end
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic random_request();
      int                  roll;
      logic [ACTION_W-1:0] act;
      roll = $urandom_range(0, 99);
      if (roll < 38)      act = ACT_INSERT;
      else if (roll < 55) act = ACT_DELETE;
      else if (roll < 77) act = ACT_SEARCH;
      else if (roll < 87) act = ACT_LIST;
      else if (roll < 93) act = ACT_DRAIN;
      else                act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      send_req(act, pick_key(), 7'($urandom()));
   endtask

   // sender holds off until the table has answered everything
   task automatic hold_until_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic check_reply();
      table_reply_type want;
      if (replies_due.size() == 0) begin
         report_mismatch("response with nothing owed", rsp_tdata, '0);
         return;
      end
      want = replies_due.pop_front();
      if (rsp_tuser !== want.status)
         report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
      if (rsp_tdata[15:0] !== want.key)
         report_mismatch("found_key", 32'(rsp_tdata[15:0]), 32'(want.key));
      if (rsp_tdata[22:16] !== want.age)
         report_mismatch("found_age", 32'(rsp_tdata[22:16]), 32'(want.age));
      if (rsp_tlast !== want.last)
         report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
      if (rsp_tdata[29:23] !== want.entries)
         report_mismatch("entries", 32'(rsp_tdata[29:23]), 32'(want.entries));
   endtask

   // compare each accepted response with the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_reply();
   end

   // response side stalls in bursts
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // main request sequence
   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= ACT_INSERT;
      shadow_fill = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_req(directed_rows[r].act, directed_rows[r].key, directed_rows[r].age,
                  directed_rows[r].typed, directed_rows[r].reply);
      hold_until_quiet();

      repeat (160) random_request();
      hold_until_quiet();

      // fill to capacity, then full, duplicate and edge lookups, a list, deletes, inserts and a drain
      while (shadow_fill < CAP) send_req(ACT_INSERT, 16'($urandom()), 7'($urandom()));
      repeat (4) send_req(ACT_INSERT, pick_key(), 7'($urandom()));
      send_req(ACT_INSERT, shadow_keys[0], 7'($urandom()));
      send_req(ACT_INSERT, shadow_keys[CAP-1], 7'($urandom()));
      send_req(ACT_SEARCH, shadow_keys[0], 7'($urandom()));
      send_req(ACT_SEARCH, shadow_keys[CAP-1], 7'($urandom()));
      send_req(ACT_LIST, 16'($urandom()), 7'($urandom()));
      repeat (10)
         send_req(ACT_DELETE, shadow_keys[$urandom_range(0, shadow_fill - 1)], 7'($urandom()));
      repeat (12) send_req(ACT_INSERT, 16'($urandom()), 7'($urandom()));
      send_req(ACT_DRAIN, 16'($urandom()), 7'($urandom()));

      repeat (120) random_request();
      calm = 1'b1;
      repeat (60) random_request();
      req_tvalid <= 1'b0;

      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // hang guard
   initial begin
      #20ms;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
